/* sv/dbp_pkg.sv */
// ----------------------------------------------------------------------------
// dbp_pkg
// Shared types, constants and tables of the block discretization point unit.
// ----------------------------------------------------------------------------
package dbp_pkg;

	localparam int unsigned COORD_W     = 32;
	localparam int unsigned SIZE_W      = 31;
	localparam int unsigned CFG_W       = 31;
	localparam int unsigned WEIGHT_W    = 17;
	localparam int unsigned PPA_W       = 3;
	localparam int unsigned IDX_W       = 2;
	localparam int unsigned NAX         = 3;
	localparam int unsigned AX_W        = $clog2(NAX);
	localparam int unsigned STEP_W      = 3;
	localparam int unsigned REG_IDX_W   = 3;
	localparam int unsigned MAX_PPA_DEF = 4;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// register map
	localparam logic [REG_IDX_W-1:0] REG_SIZE_X = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SIZE_Y = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SIZE_Z = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PPA    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_GAUSS  = 3'd4;

	localparam logic [PPA_W-1:0]  PPA_RESET = 3'd4;
	localparam logic [PPA_W-1:0]  GAUSS_N   = 3'd4;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * NAX - 1);

	// Gauss-Legendre offsets, Q0.30, and axis weights, Q0.20
	localparam logic [63:0] GAUSS_OFF_OUTER =
		((64'd4305681558 << 30) + 64'd5000000000) / 64'd10000000000;
	localparam logic [63:0] GAUSS_OFF_INNER =
		((64'd1699905218 << 30) + 64'd5000000000) / 64'd10000000000;
	localparam logic [63:0] GW_O =
		((64'd1739274226 << 20) + 64'd5000000000) / 64'd10000000000;
	localparam logic [63:0] GW_I =
		((64'd3260725774 << 20) + 64'd5000000000) / 64'd10000000000;
	localparam logic [63:0] GW_ONE = 64'd1 << 20;
	localparam logic [63:0] GW_RND = 64'd1 << 43;

	localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 17'd65536;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ZERO = 17'd0;

	// products of axis weights, by used axes and count of outer indexes
	localparam logic [WEIGHT_W-1:0] GW1_0 = WEIGHT_W'((GW_I * GW_ONE * GW_ONE + GW_RND) >> 44);
	localparam logic [WEIGHT_W-1:0] GW1_1 = WEIGHT_W'((GW_O * GW_ONE * GW_ONE + GW_RND) >> 44);
	localparam logic [WEIGHT_W-1:0] GW2_0 = WEIGHT_W'((GW_I * GW_I * GW_ONE + GW_RND) >> 44);
	localparam logic [WEIGHT_W-1:0] GW2_1 = WEIGHT_W'((GW_O * GW_I * GW_ONE + GW_RND) >> 44);
	localparam logic [WEIGHT_W-1:0] GW2_2 = WEIGHT_W'((GW_O * GW_O * GW_ONE + GW_RND) >> 44);
	localparam logic [WEIGHT_W-1:0] GW3_0 = WEIGHT_W'((GW_I * GW_I * GW_I + GW_RND) >> 44);
	localparam logic [WEIGHT_W-1:0] GW3_1 = WEIGHT_W'((GW_O * GW_I * GW_I + GW_RND) >> 44);
	localparam logic [WEIGHT_W-1:0] GW3_2 = WEIGHT_W'((GW_O * GW_O * GW_I + GW_RND) >> 44);
	localparam logic [WEIGHT_W-1:0] GW3_3 = WEIGHT_W'((GW_O * GW_O * GW_O + GW_RND) >> 44);

	// regular weights, 65536 / total rounded half up
	localparam logic [WEIGHT_W-1:0] RW_1  = WEIGHT_W'((65536 + 1 / 2) / 1);
	localparam logic [WEIGHT_W-1:0] RW_2  = WEIGHT_W'((65536 + 2 / 2) / 2);
	localparam logic [WEIGHT_W-1:0] RW_3  = WEIGHT_W'((65536 + 3 / 2) / 3);
	localparam logic [WEIGHT_W-1:0] RW_4  = WEIGHT_W'((65536 + 4 / 2) / 4);
	localparam logic [WEIGHT_W-1:0] RW_8  = WEIGHT_W'((65536 + 8 / 2) / 8);
	localparam logic [WEIGHT_W-1:0] RW_9  = WEIGHT_W'((65536 + 9 / 2) / 9);
	localparam logic [WEIGHT_W-1:0] RW_16 = WEIGHT_W'((65536 + 16 / 2) / 16);
	localparam logic [WEIGHT_W-1:0] RW_27 = WEIGHT_W'((65536 + 27 / 2) / 27);
	localparam logic [WEIGHT_W-1:0] RW_64 = WEIGHT_W'((65536 + 64 / 2) / 64);

	typedef enum logic [1:0] {
		KIND_POINT,
		KIND_BAD,
		KIND_BLOCK
	} dbp_kind_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CALC,
		F_WAIT,
		F_PUSH
	} dbp_fstate_t;

	typedef struct packed {
		dbp_kind_t                      kind;
		logic signed [COORD_W-1:0]      loc_x;
		logic signed [COORD_W-1:0]      loc_y;
		logic signed [COORD_W-1:0]      loc_z;
		logic                           use_y;
		logic                           use_z;
		logic                           gauss;
		logic [PPA_W-1:0]               n;
		logic [WEIGHT_W-1:0]            weight;
		logic [NAX-1:0][SIZE_W-1:0]     mag_outer;
		logic [NAX-1:0][SIZE_W-1:0]     mag_inner;
	} dbp_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dbp_qstat_t;

	function automatic logic [WEIGHT_W-1:0] regular_weight(
		input logic [PPA_W-1:0] n,
		input logic [1:0]       ndim
	);
		logic [WEIGHT_W-1:0] w;
		case ({n, ndim})
			{3'd1, 2'd1}, {3'd1, 2'd2}, {3'd1, 2'd3}: w = RW_1;
			{3'd2, 2'd1}: w = RW_2;
			{3'd2, 2'd2}: w = RW_4;
			{3'd2, 2'd3}: w = RW_8;
			{3'd3, 2'd1}: w = RW_3;
			{3'd3, 2'd2}: w = RW_9;
			{3'd3, 2'd3}: w = RW_27;
			{3'd4, 2'd1}: w = RW_4;
			{3'd4, 2'd2}: w = RW_16;
			{3'd4, 2'd3}: w = RW_64;
			default:      w = WEIGHT_ZERO;
		endcase
		return w;
	endfunction

	function automatic logic [WEIGHT_W-1:0] gauss_weight(
		input logic [1:0] ndim,
		input logic [1:0] nout
	);
		logic [WEIGHT_W-1:0] w;
		case ({ndim, nout})
			{2'd1, 2'd0}: w = GW1_0;
			{2'd1, 2'd1}: w = GW1_1;
			{2'd2, 2'd0}: w = GW2_0;
			{2'd2, 2'd1}: w = GW2_1;
			{2'd2, 2'd2}: w = GW2_2;
			{2'd3, 2'd0}: w = GW3_0;
			{2'd3, 2'd1}: w = GW3_1;
			{2'd3, 2'd2}: w = GW3_2;
			{2'd3, 2'd3}: w = GW3_3;
			default:      w = WEIGHT_ZERO;
		endcase
		return w;
	endfunction

endpackage

/* sv/dbp_in_if.sv */
// ----------------------------------------------------------------------------
// dbp_in_if
// Location channel: valid/ready handshake with the prediction location.
// ----------------------------------------------------------------------------
interface dbp_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [dbp_pkg::COORD_W-1:0] loc_x;
	logic signed [dbp_pkg::COORD_W-1:0] loc_y;
	logic signed [dbp_pkg::COORD_W-1:0] loc_z;
	logic                               block_req;

	modport source(output valid, loc_x, loc_y, loc_z, block_req, input ready);
	modport sink(input valid, loc_x, loc_y, loc_z, block_req, output ready);
endinterface

/* sv/dbp_out_if.sv */
// ----------------------------------------------------------------------------
// dbp_out_if
// Point channel: valid/ready handshake with one discretization point.
// ----------------------------------------------------------------------------
interface dbp_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [dbp_pkg::COORD_W-1:0]  point_x;
	logic signed [dbp_pkg::COORD_W-1:0]  point_y;
	logic signed [dbp_pkg::COORD_W-1:0]  point_z;
	logic [dbp_pkg::WEIGHT_W-1:0]        point_weight;
	logic                                last_point;
	logic                                bad_dims;

	modport source(output valid, point_x, point_y, point_z, point_weight, last_point,
		bad_dims, input ready);
	modport sink(input valid, point_x, point_y, point_z, point_weight, last_point,
		bad_dims, output ready);
endinterface

/* sv/dbp_front.sv */
// ----------------------------------------------------------------------------
// dbp_front
// Configuration registers, classification of locations and per-axis offset
// magnitudes through one shared multiplier; finished jobs go to the queue.
// ----------------------------------------------------------------------------
module dbp_front #(
	parameter int unsigned MAX_POINTS_PER_AXIS = dbp_pkg::MAX_PPA_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	dbp_in_if.sink                         loc,
	input  logic                           cfg_we,
	input  logic [dbp_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [dbp_pkg::CFG_W-1:0]      cfg_wdata,
	input  dbp_pkg::dbp_qstat_t            qstat,
	output logic                           push,
	output dbp_pkg::dbp_job_t              job
);

	localparam logic [dbp_pkg::PPA_W-1:0] MAXP = dbp_pkg::PPA_W'(MAX_POINTS_PER_AXIS);

	logic [dbp_pkg::NAX-1:0][dbp_pkg::SIZE_W-1:0] size_q;
	logic [dbp_pkg::PPA_W-1:0]                    ppa_q;
	logic                                         gauss_q;

	dbp_pkg::dbp_fstate_t      state_q, state_d;
	logic [dbp_pkg::STEP_W-1:0] step_q;
	dbp_pkg::dbp_job_t         job_q;

	logic                       acc;
	logic                       ux, uy, uz;
	dbp_pkg::dbp_kind_t         kind_in;
	logic [dbp_pkg::PPA_W-1:0]  n_reg, n_in;
	logic [1:0]                 ndim;
	logic [dbp_pkg::WEIGHT_W-1:0] weight_in;

	logic [dbp_pkg::AX_W-1:0]   axis;
	logic                       inner;
	logic [dbp_pkg::SIZE_W-1:0] size_sel;
	logic [1:0]                 a_mul;
	logic [33:0]                x_val;
	logic [31:0]                op_a, op_b;
	logic [63:0]                prod;

	logic                       valid_s1;
	logic [63:0]                prod_s1;
	logic [33:0]                x_s1;
	logic [dbp_pkg::AX_W-1:0]   axis_s1;
	logic                       inner_s1;
	logic [63:0]                g_rnd;
	logic [dbp_pkg::SIZE_W-1:0] mag;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= '0;
			ppa_q   <= dbp_pkg::PPA_RESET;
			gauss_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				dbp_pkg::REG_SIZE_X: size_q[0] <= cfg_wdata[dbp_pkg::SIZE_W-1:0];
				dbp_pkg::REG_SIZE_Y: size_q[1] <= cfg_wdata[dbp_pkg::SIZE_W-1:0];
				dbp_pkg::REG_SIZE_Z: size_q[2] <= cfg_wdata[dbp_pkg::SIZE_W-1:0];
				dbp_pkg::REG_PPA:    ppa_q     <= cfg_wdata[dbp_pkg::PPA_W-1:0];
				dbp_pkg::REG_GAUSS:  gauss_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// classification
	always_comb begin
		ux = size_q[0] != '0;
		uy = size_q[1] != '0;
		uz = size_q[2] != '0;
		if (!loc.block_req || !(ux || uy || uz))
			kind_in = dbp_pkg::KIND_POINT;
		else if (!ux || (uz && !uy))
			kind_in = dbp_pkg::KIND_BAD;
		else
			kind_in = dbp_pkg::KIND_BLOCK;
		if (ppa_q == '0)
			n_reg = 3'd1;
		else if (ppa_q > MAXP)
			n_reg = MAXP;
		else
			n_reg = ppa_q;
		n_in = gauss_q ? dbp_pkg::GAUSS_N : n_reg;
		ndim = 2'd1 + 2'(uy) + 2'(uz);
		case (kind_in)
			dbp_pkg::KIND_POINT: weight_in = dbp_pkg::WEIGHT_ONE;
			dbp_pkg::KIND_BLOCK: weight_in = dbp_pkg::regular_weight(n_in, ndim);
			default:             weight_in = dbp_pkg::WEIGHT_ZERO;
		endcase
	end

	// offset operand selection for the current step
	always_comb begin
		axis     = step_q[dbp_pkg::AX_W:1];
		inner    = step_q[0];
		size_sel = size_q[axis];
		if (!inner)
			a_mul = 2'(job_q.n - 3'd1);
		else if (job_q.n >= 3'd3)
			a_mul = 2'(job_q.n - 3'd3);
		else
			a_mul = 2'd0;
		x_val = 34'(size_sel) * 34'(a_mul) + 34'(job_q.n);
		if (job_q.gauss) begin
			op_a = 32'(size_sel);
			op_b = inner ? dbp_pkg::GAUSS_OFF_INNER[31:0] : dbp_pkg::GAUSS_OFF_OUTER[31:0];
		end else begin
			op_a = x_val[32:1];
			op_b = dbp_pkg::RECIP3;
		end
		prod = op_a * op_b;
	end

	// magnitude from the registered product; x_s1 already holds the rounding term
	always_comb begin
		g_rnd = prod_s1 + (64'd1 << 29);
		if (job_q.gauss)
			mag = g_rnd[60:30];
		else begin
			case (job_q.n)
				3'd2:    mag = x_s1[32:2];
				3'd3:    mag = prod_s1[63:33];
				3'd4:    mag = x_s1[33:3];
				default: mag = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dbp_pkg::F_IDLE;
			step_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= state_q == dbp_pkg::F_CALC;
			if (acc)
				step_q <= '0;
			else if (state_q == dbp_pkg::F_CALC)
				step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= prod;
		x_s1     <= x_val;
		axis_s1  <= axis;
		inner_s1 <= inner;
		if (acc) begin
			job_q.kind   <= kind_in;
			job_q.loc_x  <= loc.loc_x;
			job_q.loc_y  <= loc.loc_y;
			job_q.loc_z  <= loc.loc_z;
			job_q.use_y  <= uy;
			job_q.use_z  <= uz;
			job_q.gauss  <= gauss_q;
			job_q.n      <= n_in;
			job_q.weight <= weight_in;
		end
		if (valid_s1) begin
			if (inner_s1)
				job_q.mag_inner[axis_s1] <= mag;
			else
				job_q.mag_outer[axis_s1] <= mag;
		end
	end

	always_comb begin
		state_d   = state_q;
		loc.ready = 1'b0;
		push      = 1'b0;
		case (state_q)
			dbp_pkg::F_IDLE: begin
				loc.ready = 1'b1;
				if (loc.valid)
					state_d = (kind_in == dbp_pkg::KIND_BLOCK) ? dbp_pkg::F_CALC
						: dbp_pkg::F_PUSH;
			end
			dbp_pkg::F_CALC: begin
				if (step_q == dbp_pkg::LAST_STEP)
					state_d = dbp_pkg::F_WAIT;
			end
			dbp_pkg::F_WAIT: begin
				state_d = dbp_pkg::F_PUSH;
			end
			dbp_pkg::F_PUSH: begin
				push = !qstat.full;
				if (!qstat.full)
					state_d = dbp_pkg::F_IDLE;
			end
			default: state_d = dbp_pkg::F_IDLE;
		endcase
	end

	assign acc = loc.valid && loc.ready;
	assign job = job_q;

endmodule

/* sv/dbp_fifo.sv */
// ----------------------------------------------------------------------------
// dbp_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module dbp_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dbp_pkg::dbp_job_t   wdata,
	input  logic                pop,
	output dbp_pkg::dbp_job_t   rdata,
	output dbp_pkg::dbp_qstat_t qstat
);

	localparam logic [dbp_pkg::QPTR_W-1:0] PTR_LAST = dbp_pkg::QPTR_W'(dbp_pkg::QUEUE_DEPTH - 1);
	localparam logic [dbp_pkg::QCNT_W-1:0] CNT_FULL = dbp_pkg::QCNT_W'(dbp_pkg::QUEUE_DEPTH);

	dbp_pkg::dbp_job_t            mem_q [dbp_pkg::QUEUE_DEPTH];
	logic [dbp_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [dbp_pkg::QCNT_W-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	assign rdata       = mem_q[rd_ptr_q];
	assign qstat.full  = cnt_q == CNT_FULL;
	assign qstat.empty = cnt_q == '0;

endmodule

/* sv/dbp_back.sv */
// ----------------------------------------------------------------------------
// dbp_back
// Walks the k, l, m grid of the job at the queue head and emits one point per
// cycle through an output register, unless the queue is empty or pts stalls.
// ----------------------------------------------------------------------------
module dbp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  dbp_pkg::dbp_job_t   job,
	input  dbp_pkg::dbp_qstat_t qstat,
	output logic                pop,
	dbp_out_if.source           pts
);

	function automatic logic signed [dbp_pkg::COORD_W-1:0] axis_coord(
		input logic signed [dbp_pkg::COORD_W-1:0] lc,
		input logic [dbp_pkg::SIZE_W-1:0]         mo,
		input logic [dbp_pkg::SIZE_W-1:0]         mi,
		input logic [dbp_pkg::IDX_W-1:0]          idx,
		input logic [dbp_pkg::IDX_W-1:0]          idx_last,
		input logic [dbp_pkg::PPA_W-1:0]          n
	);
		logic                       outer;
		logic                       neg;
		logic [dbp_pkg::SIZE_W-1:0] m;
		logic signed [33:0]         d;
		logic signed [dbp_pkg::COORD_W-1:0] r;
		outer = (idx == '0) || (idx == idx_last);
		neg   = {idx, 1'b1} < n;
		m     = outer ? mo : mi;
		d     = neg ? 34'(lc) + 34'(m) : 34'(lc) - 34'(m);
		if (d > 34'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else if (d < -34'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = d[dbp_pkg::COORD_W-1:0];
		return r;
	endfunction

	logic [dbp_pkg::IDX_W-1:0] k_q, l_q, m_q;
	logic [dbp_pkg::IDX_W-1:0] n_last, ly_last, lz_last;
	logic                      grid_job, is_last, advance;
	logic                      out_k, out_l, out_m;
	logic [1:0]                ndim, nout;

	logic                                 out_valid_q;
	logic signed [dbp_pkg::COORD_W-1:0]   px_q, py_q, pz_q;
	logic [dbp_pkg::WEIGHT_W-1:0]         pw_q;
	logic                                 plast_q, pbad_q;

	logic signed [dbp_pkg::COORD_W-1:0]   px, py, pz;
	logic [dbp_pkg::WEIGHT_W-1:0]         pw;

	always_comb begin
		grid_job = job.kind == dbp_pkg::KIND_BLOCK;
		n_last   = dbp_pkg::IDX_W'(job.n - 3'd1);
		ly_last  = job.use_y ? n_last : '0;
		lz_last  = job.use_z ? n_last : '0;
		is_last  = !grid_job || ((k_q == n_last) && (l_q == ly_last) && (m_q == lz_last));
		advance  = !qstat.empty && (!out_valid_q || pts.ready);
		pop      = advance && is_last;

		out_k = (k_q == '0) || (k_q == n_last);
		out_l = job.use_y && ((l_q == '0) || (l_q == n_last));
		out_m = job.use_z && ((m_q == '0) || (m_q == n_last));
		ndim  = 2'd1 + 2'(job.use_y) + 2'(job.use_z);
		nout  = 2'(out_k) + 2'(out_l) + 2'(out_m);

		if (grid_job) begin
			px = axis_coord(job.loc_x, job.mag_outer[0], job.mag_inner[0], k_q, n_last, job.n);
			py = axis_coord(job.loc_y, job.mag_outer[1], job.mag_inner[1], l_q, n_last, job.n);
			pz = axis_coord(job.loc_z, job.mag_outer[2], job.mag_inner[2], m_q, n_last, job.n);
			pw = job.gauss ? dbp_pkg::gauss_weight(ndim, nout) : job.weight;
		end else begin
			px = job.loc_x;
			py = job.loc_y;
			pz = job.loc_z;
			pw = job.weight;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			l_q         <= '0;
			m_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				out_valid_q <= 1'b1;
			else if (pts.ready)
				out_valid_q <= 1'b0;
			if (advance) begin
				if (is_last) begin
					k_q <= '0;
					l_q <= '0;
					m_q <= '0;
				end else if (m_q != lz_last) begin
					m_q <= m_q + 1'b1;
				end else begin
					m_q <= '0;
					if (l_q != ly_last)
						l_q <= l_q + 1'b1;
					else begin
						l_q <= '0;
						k_q <= k_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			px_q    <= px;
			py_q    <= py;
			pz_q    <= pz;
			pw_q    <= pw;
			plast_q <= is_last;
			pbad_q  <= job.kind == dbp_pkg::KIND_BAD;
		end
	end

	assign pts.valid        = out_valid_q;
	assign pts.point_x      = px_q;
	assign pts.point_y      = py_q;
	assign pts.point_z      = pz_q;
	assign pts.point_weight = pw_q;
	assign pts.last_point   = plast_q;
	assign pts.bad_dims     = pbad_q;

endmodule

/* sv/block_discretization_points_unit.sv */
// A point or bad location is queued without offset computation; a block location
// first has its six offset products formed through one multiplier.
// Throughput: the back emits one point per cycle, 1 to 64 per location, unless
// the queue is empty or pts.ready stalls it; the front prepares the next
// location while the back emits the current one.
// Reset: arst_n clears queue and control; registers return to their reset values.
// ----------------------------------------------------------------------------
// block_discretization_points_unit
// Block discretization point generator: front, job queue and point emitter.
// ----------------------------------------------------------------------------
module block_discretization_points_unit #(
	parameter int unsigned MAX_POINTS_PER_AXIS = dbp_pkg::MAX_PPA_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	dbp_in_if.sink                         loc,
	dbp_out_if.source                      pts,
	input  logic                           cfg_we,
	input  logic [dbp_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [dbp_pkg::CFG_W-1:0]      cfg_wdata
);

	dbp_pkg::dbp_job_t   wjob, rjob;
	dbp_pkg::dbp_qstat_t qstat;
	logic                push, pop;

	dbp_front #(
		.MAX_POINTS_PER_AXIS(MAX_POINTS_PER_AXIS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.loc      (loc),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.qstat    (qstat),
		.push     (push),
		.job      (wjob)
	);

	dbp_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (wjob),
		.pop   (pop),
		.rdata (rjob),
		.qstat (qstat)
	);

	dbp_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.job   (rjob),
		.qstat (qstat),
		.pop   (pop),
		.pts   (pts)
	);

endmodule
